// File: rtl/sbc_pkg.sv
// Shared constants for the splitter bucket classifier.
package sbc_pkg;

    localparam int KEY_W       = 32;
    localparam int LIMIT_W     = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IDX_W       = 3;
    localparam int OUT_CNT_W   = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - OUT_CNT_W - 1;

    // Queue between the classifier and the counter stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Register index of the overflow limit; splitters occupy the indexes below it.
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT = 3'd7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd4096;

endpackage

// File: rtl/sbc_front.sv
// Classifier: counts the active splitters strictly below the incoming value.
module sbc_front #(
    parameter int BUCKETS = 8,
    parameter int BW      = 3
) (
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [sbc_pkg::KEY_W-1:0]                    value,
    input  logic [BUCKETS-2:0][sbc_pkg::KEY_W-1:0]       split_keys,
    output logic                                         push,
    input  logic                                         q_full,
    output logic [BW-1:0]                                bucket
);

    // The compares are independent; the bucket is the number that hit.
    always_comb
    begin
        bucket = '0;
        for (int i = 0; i < BUCKETS - 1; i++)
        begin
            if ($signed(split_keys[i]) < $signed(value))
            begin
                bucket = bucket + BW'(1);
            end
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

endmodule

// File: rtl/sbc_queue.sv
// Small queue of classified bucket indexes between the front and back stages.
module sbc_queue #(
    parameter int WIDTH = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]          mem_reg [sbc_pkg::QUEUE_DEPTH];
    logic [sbc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sbc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sbc_pkg::QPTR_W:0]   fill_reg, fill_next;

    assign full      = (fill_reg == (sbc_pkg::QPTR_W + 1)'(sbc_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + sbc_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + sbc_pkg::QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (sbc_pkg::QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (sbc_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/sbc_back.sv
// Counter stage: bumps the chosen bucket, checks all buckets against the limit.
module sbc_back #(
    parameter int BUCKETS     = 8,
    parameter int BW          = 3,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    input  logic [BW-1:0]                 q_bucket,
    output logic                          pop,
    input  logic [sbc_pkg::LIMIT_W-1:0]   over_limit,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [BW-1:0]                 res_bucket,
    output logic [COUNT_WIDTH-1:0]        res_count,
    output logic                          res_all_over
);

    logic [COUNT_WIDTH-1:0] counts_reg [BUCKETS];
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic                   all_over;
    logic                   valid_reg, valid_next;
    logic [BW-1:0]          bucket_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   all_over_reg;

    // The output register frees up as the downstream side takes its item.
    assign pop       = q_not_empty && (!valid_reg || m_tready);
    assign cur_count = counts_reg[q_bucket];
    assign new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_WIDTH'(1);

    always_comb
    begin
        all_over = 1'b1;
        for (int i = 0; i < BUCKETS; i++)
        begin
            if (BW'(i) == q_bucket)
            begin
                if (!(sbc_pkg::LIMIT_W'(new_count) > over_limit))
                begin
                    all_over = 1'b0;
                end
            end
            else if (!(sbc_pkg::LIMIT_W'(counts_reg[i]) > over_limit))
            begin
                all_over = 1'b0;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                counts_reg[q_bucket] <= new_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bucket_reg   <= q_bucket;
            count_reg    <= new_count;
            all_over_reg <= all_over;
        end
    end

    assign m_tvalid     = valid_reg;
    assign res_bucket   = bucket_reg;
    assign res_count    = count_reg;
    assign res_all_over = all_over_reg;

endmodule

// File: rtl/splitter_bucket_classifier.sv
// Top level of the splitter bucket classifier: config registers and stage wiring.
//
// Each item on the slave stream carries one signed 32-bit value. The block
// finds its bucket as the number of active splitters strictly below the
// value (split_key_1 .. split_key_(BUCKETS-1)), so a value equal to a
// splitter lands in the lower bucket. That bucket's counter is incremented,
// saturating at its all-ones value, and one result item leaves on the master
// stream with the bucket, its new count and a flag that is high when every
// bucket count exceeds the over_limit register.
// Configuration goes through cfg_we/cfg_addr/cfg_data: indexes 0..6 are the
// splitters, index 7 is over_limit. Write them only while no item is in
// flight. Indexes of splitters beyond BUCKETS-1 are ignored.
// Throughput is one item per cycle while m_tready stays high. The
// classifier compares the value against all splitters combinationally and
// pushes the bucket into a four-entry queue; the counter stage pops it
// into its output register, which drives m_tvalid. When the receiver
// stalls, the queue absorbs up to four items before s_tready drops.
// Reset clears all bucket counts and the splitters and sets over_limit
// to 4096; no clearing pass is needed.
module splitter_bucket_classifier #(
    parameter int BUCKETS     = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // value[31:0]
    input  logic [sbc_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // bucket_index[2:0], bucket_count[34:3], all_over_limit[35], zero pad[39:36]
    output logic [sbc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [sbc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    logic [BUCKETS-2:0][sbc_pkg::KEY_W-1:0] split_reg, split_next;
    logic [sbc_pkg::LIMIT_W-1:0]            limit_reg, limit_next;

    logic                   push;
    logic                   q_full;
    logic [BW-1:0]          front_bucket;
    logic                   pop;
    logic                   q_not_empty;
    logic [BW-1:0]          q_bucket;
    logic [BW-1:0]          res_bucket;
    logic [COUNT_WIDTH-1:0] res_count;
    logic                   res_all_over;

    // Configuration writes.
    always_comb
    begin
        split_next = split_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            if (cfg_addr == sbc_pkg::REG_LIMIT)
            begin
                limit_next = sbc_pkg::LIMIT_W'(cfg_data);
            end
            for (int i = 0; i < BUCKETS - 1; i++)
            begin
                if (cfg_addr == sbc_pkg::CFG_ADDR_W'(i))
                begin
                    split_next[i] = sbc_pkg::KEY_W'(cfg_data);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg <= '0;
            limit_reg <= sbc_pkg::LIMIT_RESET;
        end
        else
        begin
            split_reg <= split_next;
            limit_reg <= limit_next;
        end
    end

    sbc_front #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .value      (s_tdata[sbc_pkg::KEY_W-1:0]),
        .split_keys (split_reg),
        .push       (push),
        .q_full     (q_full),
        .bucket     (front_bucket)
    );

    sbc_queue #(
        .WIDTH (BW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_bucket),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_bucket)
    );

    sbc_back #(
        .BUCKETS     (BUCKETS),
        .BW          (BW),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_bucket     (q_bucket),
        .pop          (pop),
        .over_limit   (limit_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .res_bucket   (res_bucket),
        .res_count    (res_count),
        .res_all_over (res_all_over)
    );

    assign m_tdata = {{sbc_pkg::OUT_PAD_W{1'b0}},
                      res_all_over,
                      sbc_pkg::OUT_CNT_W'(res_count),
                      sbc_pkg::IDX_W'(res_bucket)};

endmodule

// File: rtl/sbc_checker.sv
// Port-level checks for the splitter bucket classifier, bound to the top level.
module sbc_checker #(
    parameter int BUCKETS = 8
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sbc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int CAPACITY = sbc_pkg::QUEUE_DEPTH + 1;

    logic       in_acc;
    logic       out_acc;
    logic [3:0] pending_reg, pending_next;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 4'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[sbc_pkg::IDX_W-1:0]) < BUCKETS))
        else $error("bucket index beyond the bucket count");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result item without an accepted input item");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending_reg) <= CAPACITY)
        else $error("more items in flight than the block can hold");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[sbc_pkg::IDX_W +: sbc_pkg::OUT_CNT_W] != '0)
        else $error("bucket count of a result is zero");

endmodule

bind splitter_bucket_classifier sbc_checker #(
    .BUCKETS (BUCKETS)
) u_sbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
